@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// shared helpers for concurrent checks on the i_clk / i_rst_n domain
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication check, masked while reset is asserted
`define CRB_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle check, masked while reset is asserted
`define CRB_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle check that also runs through reset
`define CRB_ASSERT_RST(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/crb_pkg.sv @@
// ----------------------------------------------------------------------------
// crb_pkg
// types, widths and tables for the range / bearing cordic pipeline
// ----------------------------------------------------------------------------
package crb_pkg;

    // sizing
    localparam int ITERATIONS   = 16;
    localparam int COORD_WIDTH  = 16;
    localparam int GUARD_BITS   = 8;
    localparam int ATAN_ENTRIES = 24;
    localparam int CELLS        = (ITERATIONS < ATAN_ENTRIES) ? ITERATIONS : ATAN_ENTRIES;
    localparam int ATAN_IDX_W   = $clog2(ATAN_ENTRIES);
    localparam int FIELD_W      = 16;
    localparam int OUT_W        = 16;

    // datapath widths: magnitude with guard bits plus growth headroom
    localparam int VEC_W       = COORD_WIDTH + GUARD_BITS + 3;
    localparam int MAG_W       = VEC_W - 1;
    localparam int ANGLE_W     = 32;
    localparam int INV_GAIN_W  = 32;
    localparam int PROD_W      = MAG_W + INV_GAIN_W;
    localparam int RANGE_SHIFT = INV_GAIN_W + GUARD_BITS;
    localparam int SAT_W       = PROD_W + 1;
    localparam int TURN_SHIFT  = ANGLE_W - OUT_W;
    localparam int Q_W         = OUT_W - 1;
    localparam int RANGE_MAX   = 65535;

    // cordic inverse gain, 2^-32 units
    localparam logic [INV_GAIN_W-1:0] INV_GAIN = 32'd2608131496;

    // angle codes, 1/65536 turn
    localparam logic [OUT_W-1:0] ZERO_TURN          = 16'd0;
    localparam logic [OUT_W-1:0] QUARTER_TURN       = 16'd16384;
    localparam logic [OUT_W-1:0] HALF_TURN          = 16'd32768;
    localparam logic [OUT_W-1:0] THREE_QUARTER_TURN = 16'd49152;

    // atan(2^-i) in 2^-32 turn
    localparam logic [ANGLE_W-1:0] ATAN_TURNS [ATAN_ENTRIES] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
        32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
    };

    // input beat
    typedef struct packed {
        logic signed [FIELD_W-1:0] pos_x;
        logic signed [FIELD_W-1:0] pos_y;
    } t_in;

    // output beat
    typedef struct packed {
        logic [OUT_W-1:0] range_out;
        logic [OUT_W-1:0] bearing_out;
    } t_out;

    // rotating vector and angle accumulator
    typedef struct packed {
        logic [VEC_W-1:0]   a;
        logic [VEC_W-1:0]   b;
        logic [ANGLE_W-1:0] z;
    } t_vec;

    // quadrant and axis info riding beside the vector
    typedef struct packed {
        logic                   x_neg;
        logic                   y_neg;
        logic                   x_zero;
        logic                   y_zero;
        logic [COORD_WIDTH-1:0] ax;
        logic [COORD_WIDTH-1:0] ay;
    } t_tag;

    // clip a wide unsigned value to the output field
    function automatic logic [OUT_W-1:0] sat_range(input logic [SAT_W-1:0] v);
        return (v > SAT_W'(RANGE_MAX)) ? OUT_W'(RANGE_MAX) : v[OUT_W-1:0];
    endfunction

endpackage

@@ rtl/core/crb_cell.sv @@
// ----------------------------------------------------------------------------
// crb_cell
// one vectoring micro-rotation, registered, handed to the next cell
// ----------------------------------------------------------------------------
module crb_cell import crb_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic [ATAN_IDX_W-1:0] i_shift,
    input  logic                  i_valid,
    input  t_vec                  i_vec,
    input  t_tag                  i_tag,
    output logic                  o_valid,
    output t_vec                  o_vec,
    output t_tag                  o_tag
);

    logic                r_valid;
    t_vec                r_vec;
    t_tag                r_tag;
    t_vec                n_vec;
    logic [VEC_W-1:0]    w_da;
    logic [VEC_W-1:0]    w_db;
    logic [ANGLE_W-1:0]  w_atan;
    logic                w_pos;

    // floor shifts of the cross terms
    assign w_da   = $unsigned($signed(i_vec.b) >>> i_shift);
    assign w_db   = $unsigned($signed(i_vec.a) >>> i_shift);
    assign w_atan = ATAN_TURNS[i_shift];
    assign w_pos  = !i_vec.b[VEC_W-1];

    // rotate toward b = 0
    always_comb begin
        if (w_pos) begin
            n_vec.a = i_vec.a + w_da;
            n_vec.b = i_vec.b - w_db;
            n_vec.z = i_vec.z + w_atan;
        end else begin
            n_vec.a = i_vec.a - w_da;
            n_vec.b = i_vec.b + w_db;
            n_vec.z = i_vec.z - w_atan;
        end
    end

    // beat valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vec <= n_vec;
            r_tag <= i_tag;
        end
    end

    assign o_valid = r_valid;
    assign o_vec   = r_vec;
    assign o_tag   = r_tag;

endmodule

@@ rtl/core/crb_finish.sv @@
// ----------------------------------------------------------------------------
// crb_finish
// gain correction and bearing fold: multiply stage, then output register
// ----------------------------------------------------------------------------
module crb_finish import crb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_vec i_vec,
    input  t_tag i_tag,
    output logic o_valid,
    output t_out o_data
);

    logic                r_mul_valid;
    logic [PROD_W-1:0]   r_prod;
    logic [Q_W-1:0]      r_q;
    t_tag                r_tag;
    logic                r_valid;
    t_out                r_out;

    logic [MAG_W-1:0]    w_mag;
    logic [ANGLE_W-1:0]  w_zr;
    logic [OUT_W-1:0]    w_qs;
    logic [Q_W-1:0]      n_q;
    logic [SAT_W-1:0]    w_rnd;
    logic [OUT_W-1:0]    w_range;
    logic [OUT_W-1:0]    w_qe;
    t_out                n_out;

    // negative magnitude reads as zero
    assign w_mag = i_vec.a[VEC_W-1] ? '0 : i_vec.a[MAG_W-1:0];

    // angle rounded to 1/65536 turn, clamped to one quadrant
    assign w_zr = i_vec.z + ANGLE_W'(1 << (TURN_SHIFT - 1));
    assign w_qs = w_zr[ANGLE_W-1:TURN_SHIFT];

    always_comb begin
        if (w_qs[OUT_W-1]) begin
            n_q = '0;
        end else if (w_qs > QUARTER_TURN) begin
            n_q = QUARTER_TURN[Q_W-1:0];
        end else begin
            n_q = w_qs[Q_W-1:0];
        end
    end

    // multiply stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_valid <= 1'b0;
        end else if (i_en) begin
            r_mul_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= PROD_W'(w_mag) * PROD_W'(INV_GAIN);
            r_q    <= n_q;
            r_tag  <= i_tag;
        end
    end

    // round-half-up of the corrected magnitude
    assign w_rnd   = SAT_W'(r_prod) + (SAT_W'(1) << (RANGE_SHIFT - 1));
    assign w_range = sat_range(w_rnd >> RANGE_SHIFT);
    assign w_qe    = OUT_W'(r_q);

    // axis cases and quadrant fold
    always_comb begin
        if (r_tag.x_zero && r_tag.y_zero) begin
            n_out.range_out   = '0;
            n_out.bearing_out = ZERO_TURN;
        end else if (r_tag.x_zero) begin
            n_out.range_out   = sat_range(SAT_W'(r_tag.ay));
            n_out.bearing_out = r_tag.y_neg ? HALF_TURN : ZERO_TURN;
        end else if (r_tag.y_zero) begin
            n_out.range_out   = sat_range(SAT_W'(r_tag.ax));
            n_out.bearing_out = r_tag.x_neg ? THREE_QUARTER_TURN : QUARTER_TURN;
        end else begin
            n_out.range_out = w_range;
            unique case ({r_tag.x_neg, r_tag.y_neg})
                2'b00:   n_out.bearing_out = w_qe;
                2'b01:   n_out.bearing_out = HALF_TURN - w_qe;
                2'b11:   n_out.bearing_out = HALF_TURN + w_qe;
                default: n_out.bearing_out = ZERO_TURN - w_qe;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= r_mul_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_out;

endmodule

@@ rtl/core/cartesian_to_range_bearing.sv @@
// ----------------------------------------------------------------------------
// cartesian_to_range_bearing
// position (x, y) to range and clockwise bearing from +y, pipelined cordic
// ----------------------------------------------------------------------------
// Takes one Q8.8 position per clock and returns its range (unsigned Q8.8) and
// its bearing (1/65536 turn, clockwise from +y) through one input register,
// one registered cell per micro-rotation (16 by default), a gain multiply
// stage and the output register. Throughput is one beat per cycle; while a
// finished beat is held on a stalled output the whole chain freezes and
// o_in_stall is raised in the same cycle.
// ----------------------------------------------------------------------------
module cartesian_to_range_bearing import crb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

`include "assert_macros.svh"

    logic                   w_en;
    logic [COORD_WIDTH-1:0] w_rx;
    logic [COORD_WIDTH-1:0] w_ry;
    t_tag                   n_tag;
    t_vec                   n_vec;
    logic                   r_valid0;
    t_vec                   r_vec0;
    t_tag                   r_tag0;

    logic                   w_vld [CELLS+1];
    t_vec                   w_vec [CELLS+1];
    t_tag                   w_tag [CELLS+1];

    // chain advances unless a finished beat is held
    assign w_en       = !(o_out_valid && i_out_stall);
    assign o_in_stall = !w_en;

    // sign, axis flags and magnitudes
    assign w_rx = COORD_WIDTH'($unsigned(i_in_data.pos_x));
    assign w_ry = COORD_WIDTH'($unsigned(i_in_data.pos_y));

    always_comb begin
        n_tag.x_neg  = w_rx[COORD_WIDTH-1];
        n_tag.y_neg  = w_ry[COORD_WIDTH-1];
        n_tag.x_zero = (w_rx == '0);
        n_tag.y_zero = (w_ry == '0);
        n_tag.ax     = w_rx[COORD_WIDTH-1] ? -w_rx : w_rx;
        n_tag.ay     = w_ry[COORD_WIDTH-1] ? -w_ry : w_ry;
        n_vec.a      = {{(VEC_W-COORD_WIDTH-GUARD_BITS){1'b0}}, n_tag.ay,
                        {GUARD_BITS{1'b0}}};
        n_vec.b      = {{(VEC_W-COORD_WIDTH-GUARD_BITS){1'b0}}, n_tag.ax,
                        {GUARD_BITS{1'b0}}};
        n_vec.z      = '0;
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid0 <= 1'b0;
        end else if (w_en) begin
            r_valid0 <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_vec0 <= n_vec;
            r_tag0 <= n_tag;
        end
    end

    assign w_vld[0] = r_valid0;
    assign w_vec[0] = r_vec0;
    assign w_tag[0] = r_tag0;

    // micro-rotation cells
    for (genvar g = 0; g < CELLS; g++) begin : g_cell
        crb_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_shift (ATAN_IDX_W'(g)),
            .i_valid (w_vld[g]),
            .i_vec   (w_vec[g]),
            .i_tag   (w_tag[g]),
            .o_valid (w_vld[g+1]),
            .o_vec   (w_vec[g+1]),
            .o_tag   (w_tag[g+1])
        );
    end

    // gain correction and fold
    crb_finish u_finish (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_vld[CELLS]),
        .i_vec   (w_vec[CELLS]),
        .i_tag   (w_tag[CELLS]),
        .o_valid (o_out_valid),
        .o_data  (o_out_data)
    );

    // checks
    `CRB_ASSERT_RST(a_reset_empty, !i_rst_n, !o_out_valid && !w_vld[0], "pipeline not empty after reset")
    `CRB_ASSERT_NXT(a_hold_chain, o_out_valid && i_out_stall, $stable(w_vld[CELLS]) && $stable(w_vec[CELLS]), "chain moved under stall")
    `CRB_ASSERT_IMP(a_origin_only, o_out_valid && o_out_data.range_out == '0, o_out_data.bearing_out == ZERO_TURN, "zero range with nonzero bearing")

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench for cartesian_to_range_bearing
// drives Q8.8 positions through the cordic pipeline and checks every range
// and bearing beat against a bit-exact vectoring model, in order, while both
// sides idle and stall at random, with one long output hold-off and one
// sender pause until the pipeline drains
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import crb_pkg::t_in;
    import crb_pkg::t_out;

    // model sizing and constants
    localparam int          ROTATIONS     = 16;
    localparam int          PIPE_LATENCY  = ROTATIONS + 3;
    localparam int          GUARD         = 8;
    localparam longint      GAIN_INV_Q32  = 64'd2608131496;
    localparam int          QUARTER       = 16384;
    localparam int          HALF          = 32768;
    localparam int          THREE_QUARTER = 49152;
    localparam int          FULL_TURN     = 65536;
    localparam int          RANGE_CEIL    = 65535;
    localparam int          RANDOM_COUNT  = 1700;
    localparam int          TAIL_ITEMS    = 200;
    localparam int          PAUSE_AT      = 900;
    localparam int          HOLDOFF_AT    = 400;
    localparam int          HOLDOFF_LEN   = 80;

    // atan(2^-i) in 2^-32 turn
    localparam logic [31:0] ATAN_STEP [24] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
        32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
    };

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic o_in_stall;
    t_in  i_in_data   = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_out o_out_data;

    // positions waiting to be sent, range / bearing beats still owed
    t_in  positions_to_send [$];
    t_out range_bearing_due [$];

    int   fail_count     = 0;
    int   directed_count = 0;
    int   sent_count     = 0;
    int   taken_count    = 0;
    int   result_count   = 0;
    int   backpress_cyc  = 0;
    logic in_taken       = 1'b0;

    cartesian_to_range_bearing dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // vectoring cordic on (|y|, |x|), folded by quadrant
    function automatic t_out to_range_bearing(input t_in pos);
        t_out   res;
        longint x, y, ax, ay, a, b, z, q, da, db;
        longint unsigned ua, hi, lo, t, rng;
        int     brg;
        x   = longint'(pos.pos_x);
        y   = longint'(pos.pos_y);
        ax  = (x < 0) ? -x : x;
        ay  = (y < 0) ? -y : y;
        res = '0;
        // axes and origin are exact
        if (x == 0 && y == 0) begin
            return res;
        end
        if (x == 0) begin
            res.range_out   = 16'(ay);
            res.bearing_out = (y > 0) ? 16'd0 : 16'(HALF);
            return res;
        end
        if (y == 0) begin
            res.range_out   = 16'(ax);
            res.bearing_out = (x > 0) ? 16'(QUARTER) : 16'(THREE_QUARTER);
            return res;
        end
        a = ay <<< GUARD;
        b = ax <<< GUARD;
        z = 0;
        for (int i = 0; i < ROTATIONS; i++) begin
            da = b >>> i;
            db = a >>> i;
            if (b >= 0) begin
                a = a + da;
                b = b - db;
                z = z + longint'(ATAN_STEP[i]);
            end else begin
                a = a - da;
                b = b + db;
                z = z - longint'(ATAN_STEP[i]);
            end
        end
        // gain correction with round half up
        ua  = (a > 0) ? longint'(a) : 0;
        hi  = ua >> 16;
        lo  = ua & 64'hFFFF;
        t   = hi * GAIN_INV_Q32 + ((lo * GAIN_INV_Q32) >> 16);
        rng = (t + (64'd1 << 23)) >> 24;
        res.range_out = (rng > RANGE_CEIL) ? 16'(RANGE_CEIL) : 16'(rng);
        // first-quadrant angle, rounded and clamped
        q = (z + 32768) >>> 16;
        if (q < 0) q = 0;
        if (q > QUARTER) q = QUARTER;
        if (x > 0 && y > 0) brg = int'(q);
        else if (x > 0) brg = HALF - int'(q);
        else if (y < 0) brg = HALF + int'(q);
        else brg = FULL_TURN - int'(q);
        res.bearing_out = 16'(brg);
        return res;
    endfunction

    function automatic logic in_tail();
        return positions_to_send.size() < TAIL_ITEMS;
    endfunction

    // monitor: record accepted positions, check returned beats
    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= i_in_valid && !o_in_stall;
            if (i_in_valid && o_in_stall) backpress_cyc++;
            if (i_in_valid && !o_in_stall) begin
                range_bearing_due.push_back(to_range_bearing(i_in_data));
                taken_count++;
            end
            if (o_out_valid && !i_out_stall) begin
                result_count++;
                if (range_bearing_due.size() == 0) begin
                    $error("result beat with none owed: range %0d bearing %0d",
                           o_out_data.range_out, o_out_data.bearing_out);
                    fail_count++;
                end else begin
                    want = range_bearing_due.pop_front();
                    if (o_out_data.range_out !== want.range_out) begin
                        $error("range_out mismatch: expected %0d, actual %0d",
                               want.range_out, o_out_data.range_out);
                        fail_count++;
                    end
                    if (o_out_data.bearing_out !== want.bearing_out) begin
                        $error("bearing_out mismatch: expected %0d, actual %0d",
                               want.bearing_out, o_out_data.bearing_out);
                        fail_count++;
                    end
                end
            end
        end
    end

    // driver: one position per beat, random idle bursts, one drain pause
    int   send_idle  = 0;
    logic pause_done = 1'b0;
    always @(negedge i_clk) begin
        t_in  beat;
        logic drive;
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            drive = 1'b0;
            beat  = '0;
            if (send_idle > 0) begin
                send_idle--;
            end else if (!pause_done && sent_count == PAUSE_AT) begin
                // hold until every owed beat has come back
                if (range_bearing_due.size() == 0) pause_done = 1'b1;
            end else if (positions_to_send.size() > 0) begin
                if (!in_tail() && $urandom_range(0, 7) == 0) begin
                    send_idle = $urandom_range(1, 3) - 1;
                end else begin
                    beat  = positions_to_send.pop_front();
                    drive = 1'b1;
                    sent_count++;
                end
            end
            i_in_valid <= drive;
            if (drive) i_in_data <= beat;
        end
    end

    // receiver: random stall bursts plus one long hold-off
    int   stall_left   = 0;
    int   holdoff_left = 0;
    logic holdoff_done = 1'b0;
    always @(negedge i_clk) begin
        logic stall;
        stall = 1'b0;
        if (i_rst_n) begin
            if (holdoff_left > 0) begin
                holdoff_left--;
                stall = 1'b1;
            end else if (!holdoff_done && result_count >= HOLDOFF_AT) begin
                holdoff_done = 1'b1;
                holdoff_left = HOLDOFF_LEN - 1;
                stall        = 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                stall = 1'b1;
            end else if (!in_tail() && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 3) - 1;
                stall      = 1'b1;
            end
        end
        i_out_stall <= stall;
    end

    task automatic add_position(input int px, input int py);
        t_in p;
        p.pos_x = 16'(px);
        p.pos_y = 16'(py);
        positions_to_send.push_back(p);
    endtask

    // stimulus, reset and end of run
    initial begin
        int sel, v, d;
        // origin, axis extremes, quadrant corners, wrap and clamp edges
        add_position(0, 0);
        add_position(0, 32767);
        add_position(0, -32768);
        add_position(32767, 0);
        add_position(-32768, 0);
        add_position(1, 0);
        add_position(0, -1);
        add_position(32767, 32767);
        add_position(32767, -32768);
        add_position(-32768, -32768);
        add_position(-32768, 32767);
        add_position(1, 1);
        add_position(1, -1);
        add_position(-1, -1);
        add_position(-1, 1);
        add_position(-1, 32767);
        add_position(1, 32767);
        add_position(32767, 1);
        add_position(-32768, -1);
        add_position(-1, -32768);
        add_position(256, 256);
        add_position(-300, 4000);
        add_position(12345, -6789);
        directed_count = positions_to_send.size();

        // random mix: full range, near origin, on axis, near axis, near diagonal
        for (int n = 0; n < RANDOM_COUNT; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 55) begin
                add_position(int'($urandom()), int'($urandom()));
            end else if (sel < 70) begin
                add_position($urandom_range(0, 16) - 8, $urandom_range(0, 16) - 8);
            end else if (sel < 80) begin
                v = int'($urandom());
                if ($urandom_range(0, 1)) add_position(v, 0);
                else add_position(0, v);
            end else if (sel < 90) begin
                d = $urandom_range(1, 3) * ($urandom_range(0, 1) ? 1 : -1);
                v = int'($urandom());
                if ($urandom_range(0, 1)) add_position(d, v);
                else add_position(v, d);
            end else begin
                v = $urandom_range(0, 32767);
                d = v + $urandom_range(0, 6) - 3;
                if (d > 32767) d = 32767;
                add_position($urandom_range(0, 1) ? v : -v, $urandom_range(0, 1) ? d : -d);
            end
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // drain
        while (positions_to_send.size() != 0 || i_in_valid) @(posedge i_clk);
        while (range_bearing_due.size() != 0) @(posedge i_clk);
        repeat (2 * PIPE_LATENCY) @(posedge i_clk);
        if (range_bearing_due.size() != 0) begin
            $error("%0d result beats never arrived", range_bearing_due.size());
            fail_count++;
        end

        $display("converted %0d positions (%0d directed, %0d random), %0d beats checked",
                 taken_count, directed_count, taken_count - directed_count, result_count);
        $display("input held back for %0d cycles under output back-pressure", backpress_cyc);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule
